FILE: rtl/cmct_pkg.sv
package cmct_pkg;

  // Fixed field and accumulator widths.
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned TOL_W      = 10;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned SUM_W      = 36;
  localparam int unsigned CNT_W      = 25;
  localparam int unsigned CEN_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // Shared divider sizes.
  localparam int unsigned DVD_W = SUM_W;
  localparam int unsigned DVS_W = CNT_W;
  localparam int unsigned IT_W  = 6;

  // Defaults for the top level parameters.
  localparam int unsigned MAX_DIMENSION_DEF = 4096;
  localparam int unsigned MIN_MATCHES_DEF   = 30;

  localparam logic [CHAN_W-1:0] WHITE = 8'd255;
  localparam logic [CHAN_W-1:0] RST_TARGET = 8'd0;
  localparam logic [TOL_W-1:0]  RST_TOL    = 10'd40;
  localparam logic [CHAN_W-1:0] RST_STEP   = 8'd55;
  localparam logic [DIM_W-1:0]  RST_WIDTH  = 13'd320;
  localparam logic [DIM_W-1:0]  RST_HEIGHT = 13'd240;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_RED   = 3'd0,
    CFG_TARGET_GREEN = 3'd1,
    CFG_TARGET_BLUE  = 3'd2,
    CFG_TOLERANCE    = 3'd3,
    CFG_LEVEL_STEP   = 3'd4,
    CFG_FRAME_WIDTH  = 3'd5,
    CFG_FRAME_HEIGHT = 3'd6
  } cfg_idx_e;

  // Operations run on the shared divider.
  typedef enum logic [2:0] {
    OP_RED   = 3'd0,
    OP_GREEN = 3'd1,
    OP_BLUE  = 3'd2,
    OP_AVGX  = 3'd3,
    OP_QX    = 3'd4,
    OP_AVGY  = 3'd5,
    OP_QY    = 3'd6
  } div_op_e;

  typedef struct packed {
    logic [CHAN_W-1:0] pixel_red;
    logic [CHAN_W-1:0] pixel_green;
    logic [CHAN_W-1:0] pixel_blue;
    logic              end_of_frame;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              is_match;
    logic              frame_done;
    logic [CEN_W-1:0]  centroid_x;
    logic [CEN_W-1:0]  centroid_y;
    logic              centroid_updated;
  } pix_out_t;

  typedef struct packed {
    logic [CHAN_W-1:0] target_red;
    logic [CHAN_W-1:0] target_green;
    logic [CHAN_W-1:0] target_blue;
    logic [TOL_W-1:0]  match_tolerance;
    logic [CHAN_W-1:0] level_step;
    logic [DIM_W-1:0]  frame_width;
    logic [DIM_W-1:0]  frame_height;
  } cfg_t;

  typedef struct packed {
    logic    load_pix;
    logic    div_start;
    logic    div_store;
    logic    do_match;
    logic    out_write;
    div_op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic upd_now;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/cmct_cfg.sv
module cmct_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cmct_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cmct_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output cmct_pkg::cfg_t                     cfg_o
);
  import cmct_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register file write decode; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET_RED:   cfg_d.target_red      = cfg_data_i[CHAN_W-1:0];
        CFG_TARGET_GREEN: cfg_d.target_green    = cfg_data_i[CHAN_W-1:0];
        CFG_TARGET_BLUE:  cfg_d.target_blue     = cfg_data_i[CHAN_W-1:0];
        CFG_TOLERANCE:    cfg_d.match_tolerance = cfg_data_i[TOL_W-1:0];
        CFG_LEVEL_STEP:   cfg_d.level_step      = cfg_data_i[CHAN_W-1:0];
        CFG_FRAME_WIDTH:  cfg_d.frame_width     = cfg_data_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT: cfg_d.frame_height    = cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_red      <= RST_TARGET;
      cfg_q.target_green    <= RST_TARGET;
      cfg_q.target_blue     <= RST_TARGET;
      cfg_q.match_tolerance <= RST_TOL;
      cfg_q.level_step      <= RST_STEP;
      cfg_q.frame_width     <= RST_WIDTH;
      cfg_q.frame_height    <= RST_HEIGHT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/cmct_div.sv
module cmct_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cmct_pkg::DVD_W-1:0]    dividend_i,
  input  logic [cmct_pkg::DVS_W-1:0]    divisor_i,
  input  logic [cmct_pkg::IT_W-1:0]     iters_i,
  output logic                          done_o,
  output logic [cmct_pkg::DVD_W-1:0]    quot_o,
  output logic [cmct_pkg::DVS_W-1:0]    rem_o
);
  import cmct_pkg::*;

  logic [DVD_W-1:0] dvd_q, quo_q;
  logic [DVS_W-1:0] dvs_q, rem_q;
  logic [IT_W-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   trial;
  logic             fits;
  logic [IT_W-1:0]  shamt;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign shamt = IT_W'(DVD_W) - iters_i;

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= iters_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == IT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i << shamt;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      quo_q <= {quo_q[DVD_W-2:0], fits};
      rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
    end
  end

endmodule

FILE: rtl/cmct_ctrl.sv
module cmct_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cmct_pkg::dp_status_t  status_i,
  output cmct_pkg::ctrl_cmd_t   cmd_o
);
  import cmct_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_WAIT  = 5'b00100,
    S_MATCH = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e  state_q, state_d;
  div_op_e op_q, op_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Sequencing: three channel divisions, match, then the centroid divisions at a frame end that updates, then output.
  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    cmd_o         = '0;
    cmd_o.op      = op_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_pix = 1'b1;
          op_d           = OP_RED;
          state_d        = S_START;
        end
      end
      S_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_WAIT;
      end
      S_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.div_store = 1'b1;
          case (op_q)
            OP_RED:   begin op_d = OP_GREEN; state_d = S_START; end
            OP_GREEN: begin op_d = OP_BLUE;  state_d = S_START; end
            OP_BLUE:  state_d = S_MATCH;
            OP_AVGX:  begin op_d = OP_QX;    state_d = S_START; end
            OP_QX:    begin op_d = OP_AVGY;  state_d = S_START; end
            OP_AVGY:  begin op_d = OP_QY;    state_d = S_START; end
            default:  state_d = S_OUT;
          endcase
        end
      end
      S_MATCH: begin
        cmd_o.do_match = 1'b1;
        if (status_i.upd_now) begin
          op_d    = OP_AVGX;
          state_d = S_START;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_write = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_RED;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

FILE: rtl/cmct_dp.sv
module cmct_dp #(
  parameter int unsigned MAX_DIMENSION = cmct_pkg::MAX_DIMENSION_DEF,
  parameter int unsigned MIN_MATCHES   = cmct_pkg::MIN_MATCHES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmct_pkg::pix_in_t     in_data_i,
  input  cmct_pkg::cfg_t        cfg_i,
  input  cmct_pkg::ctrl_cmd_t   cmd_i,
  output cmct_pkg::dp_status_t  status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cmct_pkg::pix_out_t    out_data_o
);
  import cmct_pkg::*;

  localparam int unsigned CW = $clog2(MAX_DIMENSION);
  localparam int unsigned DW = CW + 1;

  pix_in_t           pix_q;
  logic [CHAN_W-1:0] post_q [3];
  logic [CW-1:0]     col_q, row_q, avg_q;
  logic [SUM_W-1:0]  xsum_q, ysum_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CEN_W-1:0]  cenx_q, ceny_q;
  logic              match_q, upd_q;
  logic              out_valid_q;
  pix_out_t          out_q;

  logic [CHAN_W-1:0] step;
  logic [DW-1:0]     wdim, hdim;
  logic [DVD_W-1:0]  dividend, quot;
  logic [DVS_W-1:0]  divisor, rem;
  logic [IT_W-1:0]   iters;
  logic              div_done;
  logic [CHAN_W-1:0] chan_v;
  logic [CHAN_W-1:0] post_v;
  logic [CEN_W-1:0]  q_sat;

  logic [CHAN_W:0]   dr, dg, db;
  logic [TOL_W-1:0]  color_gap;
  logic              match_d;
  logic [SUM_W:0]    xs_add, ys_add;
  logic [CNT_W:0]    c_add;
  logic [SUM_W-1:0]  xsum_d, ysum_d;
  logic [CNT_W-1:0]  cnt_d;

  // Effective step and clamped frame size.
  assign step = (cfg_i.level_step == '0) ? CHAN_W'(1) : cfg_i.level_step;

  function automatic logic [DW-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    if (d == '0) begin
      return DW'(1);
    end else if (int'(d) > int'(MAX_DIMENSION)) begin
      return DW'(MAX_DIMENSION);
    end
    return DW'(d);
  endfunction

  assign wdim = clamp_dim(cfg_i.frame_width);
  assign hdim = clamp_dim(cfg_i.frame_height);

  // Divider operand selection.
  always_comb begin
    chan_v   = pix_q.pixel_red;
    dividend = DVD_W'(chan_v);
    divisor  = DVS_W'(step);
    iters    = IT_W'(CHAN_W);
    case (cmd_i.op)
      OP_RED:   chan_v = pix_q.pixel_red;
      OP_GREEN: chan_v = pix_q.pixel_green;
      OP_BLUE:  chan_v = pix_q.pixel_blue;
      OP_AVGX: begin
        dividend = xsum_q;
        divisor  = cnt_q;
        iters    = IT_W'(DVD_W);
      end
      OP_AVGY: begin
        dividend = ysum_q;
        divisor  = cnt_q;
        iters    = IT_W'(DVD_W);
      end
      OP_QX: begin
        dividend = DVD_W'({avg_q, 16'd0});
        divisor  = DVS_W'(wdim);
        iters    = IT_W'(CW + 16);
      end
      OP_QY: begin
        dividend = DVD_W'({avg_q, 16'd0});
        divisor  = DVS_W'(hdim);
        iters    = IT_W'(CW + 16);
      end
      default: ;
    endcase
    if (cmd_i.op == OP_RED || cmd_i.op == OP_GREEN || cmd_i.op == OP_BLUE) begin
      dividend = DVD_W'(chan_v);
    end
  end

  cmct_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .iters_i    (iters),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign post_v = chan_v - rem[CHAN_W-1:0];
  assign q_sat  = (quot > DVD_W'(16'hFFFF)) ? 16'hFFFF : quot[CEN_W-1:0];

  // Color distance and accumulator updates.
  function automatic logic [CHAN_W:0] absdiff(input logic [CHAN_W-1:0] a,
                                              input logic [CHAN_W-1:0] b);
    return (a > b) ? {1'b0, a - b} : {1'b0, b - a};
  endfunction

  assign dr        = absdiff(cfg_i.target_red, post_q[0]);
  assign dg        = absdiff(cfg_i.target_green, post_q[1]);
  assign db        = absdiff(cfg_i.target_blue, post_q[2]);
  assign color_gap = TOL_W'(dr) + TOL_W'(dg) + TOL_W'(db);
  assign match_d   = color_gap < cfg_i.match_tolerance;

  assign xs_add = {1'b0, xsum_q} + (SUM_W + 1)'(col_q);
  assign ys_add = {1'b0, ysum_q} + (SUM_W + 1)'(row_q);
  assign c_add  = {1'b0, cnt_q} + (CNT_W + 1)'(1);

  always_comb begin
    xsum_d = xsum_q;
    ysum_d = ysum_q;
    cnt_d  = cnt_q;
    if (match_d) begin
      xsum_d = xs_add[SUM_W] ? '1 : xs_add[SUM_W-1:0];
      ysum_d = ys_add[SUM_W] ? '1 : ys_add[SUM_W-1:0];
      cnt_d  = c_add[CNT_W] ? '1 : c_add[CNT_W-1:0];
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.upd_now  = pix_q.end_of_frame && (cnt_d > CNT_W'(MIN_MATCHES));
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // Pixel, posterized channels and centroid results.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pix) begin
      pix_q <= in_data_i;
    end
    if (cmd_i.div_store) begin
      case (cmd_i.op)
        OP_RED:   post_q[0] <= post_v;
        OP_GREEN: post_q[1] <= post_v;
        OP_BLUE:  post_q[2] <= post_v;
        OP_AVGX:  avg_q     <= quot[CW-1:0];
        OP_AVGY:  avg_q     <= quot[CW-1:0];
        default: ;
      endcase
    end
    if (cmd_i.do_match) begin
      match_q <= match_d;
      upd_q   <= status_o.upd_now;
    end
  end

  // Counters, sums and held centroid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      xsum_q <= '0;
      ysum_q <= '0;
      cnt_q  <= '0;
      cenx_q <= '0;
      ceny_q <= '0;
    end else begin
      if (cmd_i.div_store && cmd_i.op == OP_QX) begin
        cenx_q <= q_sat;
      end
      if (cmd_i.div_store && cmd_i.op == OP_QY) begin
        ceny_q <= q_sat;
      end
      if (cmd_i.do_match) begin
        xsum_q <= xsum_d;
        ysum_q <= ysum_d;
        cnt_q  <= cnt_d;
        if (pix_q.end_of_frame) begin
          col_q <= '0;
          row_q <= '0;
        end else if ({1'b0, col_q} + DW'(1) >= wdim) begin
          col_q <= '0;
          if (row_q < CW'(MAX_DIMENSION - 1)) begin
            row_q <= row_q + 1'b1;
          end
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      if (cmd_i.out_write && pix_q.end_of_frame) begin
        xsum_q <= '0;
        ysum_q <= '0;
        cnt_q  <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_write) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_write) begin
      out_q.out_red          <= match_q ? WHITE : post_q[0];
      out_q.out_green        <= match_q ? WHITE : post_q[1];
      out_q.out_blue         <= match_q ? WHITE : post_q[2];
      out_q.is_match         <= match_q;
      out_q.frame_done       <= pix_q.end_of_frame;
      out_q.centroid_x       <= cenx_q;
      out_q.centroid_y       <= ceny_q;
      out_q.centroid_updated <= upd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/color_match_centroid_tracker.sv
// Color match centroid tracker: takes RGB pixels in raster order, posterizes each channel
// to multiples of the level step, marks a pixel as matched (sent out white) when its L1
// distance to the target color is below the tolerance, and at each end-of-frame pixel
// updates the held centroid, as Q0.16 fractions of width and height, when more than
// MIN_MATCHES pixels matched. One item is processed at a time on a single shared
// bit-serial divider: each item passes through the accepting state, three 8-bit posterize
// divisions, a match step and an output step, and the next item is taken only after the
// current one is written to the output register. An end-of-frame pixel with an update
// also runs the averaging and normalizing divisions for x and y. A finished item waits
// in the output register while the next item is taken in. The user must write the
// registers through the configuration port, at any index from 0 (target red) to 6
// (frame height), only while the block is idle; the block itself does not enforce this.
module color_match_centroid_tracker #(
  parameter int unsigned MAX_DIMENSION = cmct_pkg::MAX_DIMENSION_DEF,
  parameter int unsigned MIN_MATCHES   = cmct_pkg::MIN_MATCHES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  cmct_pkg::pix_in_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output cmct_pkg::pix_out_t                out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cmct_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cmct_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import cmct_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  cmct_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cmct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cmct_dp #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .MIN_MATCHES   (MIN_MATCHES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/color_match_centroid_tracker_tb.sv
`timescale 1ns / 100ps

module color_match_centroid_tracker_tb;
  import cmct_pkg::*;

  localparam int unsigned MAX_DIM     = 4096;
  localparam int unsigned MIN_HITS    = 30;
  localparam int unsigned DRAIN_WAIT  = 400;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam longint unsigned SUM_LIM = (64'd1 << 36) - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pix_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pix_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  color_match_centroid_tracker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Tracker model state: registers, counters and the held centroid.
  longint unsigned reg_val [7];
  longint unsigned col_cnt, row_cnt, x_acc, y_acc, hit_cnt, cen_x, cen_y;

  pix_out_t expected_pixels [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  // A directed row: a pixel and, where obvious, its expected color and match flag.
  typedef struct {
    pix_in_t     px;
    bit          typed;
    logic [7:0]  r, g, b;
    bit          hit;
  } dir_row_t;

  // Rows run at the reset settings: step 55, target black, tolerance 40.
  dir_row_t dir_rows [8] = '{
    '{'{8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, 8'd255, 8'd255, 8'd255, 1'b1},
    '{'{8'd255, 8'd255, 8'd255, 1'b0}, 1'b1, 8'd220, 8'd220, 8'd220, 1'b0},
    '{'{8'd54,  8'd54,  8'd54,  1'b0}, 1'b1, 8'd255, 8'd255, 8'd255, 1'b1},
    '{'{8'd55,  8'd0,   8'd0,   1'b0}, 1'b1, 8'd55,  8'd0,   8'd0,   1'b0},
    '{'{8'd1,   8'd128, 8'd254, 1'b0}, 1'b1, 8'd0,   8'd110, 8'd220, 1'b0},
    '{'{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1, 8'd255, 8'd255, 8'd255, 1'b1},
    '{'{8'd170, 8'd85,  8'd0,   1'b0}, 1'b0, 8'd0,   8'd0,   8'd0,   1'b0},
    '{'{8'd255, 8'd0,   8'd255, 1'b1}, 1'b0, 8'd0,   8'd0,   8'd0,   1'b0}
  };

  function automatic longint unsigned abs_gap(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic longint unsigned clamp_size(longint unsigned d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  function automatic longint unsigned to_fraction(longint unsigned s, longint unsigned n,
                                                  longint unsigned d);
    longint unsigned q;
    q = ((s / n) << 16) / d;
    return (q > 65535) ? 65535 : q;
  endfunction

  // Posterize, match and track one pixel; returns the expected output item.
  function automatic pix_out_t track_pixel(pix_in_t px);
    longint unsigned stp, w, h, pr, pg, pb, gap_sum;
    bit hit, upd;
    pix_out_t r;
    stp = (reg_val[CFG_LEVEL_STEP] == 0) ? 1 : reg_val[CFG_LEVEL_STEP];
    w = clamp_size(reg_val[CFG_FRAME_WIDTH]);
    h = clamp_size(reg_val[CFG_FRAME_HEIGHT]);
    pr = (px.pixel_red / stp) * stp;
    pg = (px.pixel_green / stp) * stp;
    pb = (px.pixel_blue / stp) * stp;
    gap_sum = abs_gap(reg_val[CFG_TARGET_RED], pr) + abs_gap(reg_val[CFG_TARGET_GREEN], pg)
            + abs_gap(reg_val[CFG_TARGET_BLUE], pb);
    hit = gap_sum < reg_val[CFG_TOLERANCE];
    upd = 1'b0;
    if (hit) begin
      x_acc = (x_acc + col_cnt > SUM_LIM) ? SUM_LIM : x_acc + col_cnt;
      y_acc = (y_acc + row_cnt > SUM_LIM) ? SUM_LIM : y_acc + row_cnt;
      if (hit_cnt < (64'd1 << 25) - 1) hit_cnt++;
    end
    if (px.end_of_frame) begin
      if (hit_cnt > MIN_HITS) begin
        cen_x = to_fraction(x_acc, hit_cnt, w);
        cen_y = to_fraction(y_acc, hit_cnt, h);
        upd = 1'b1;
      end
      col_cnt = 0;
      row_cnt = 0;
      x_acc = 0;
      y_acc = 0;
      hit_cnt = 0;
    end else if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      if (row_cnt < MAX_DIM - 1) row_cnt++;
    end else begin
      col_cnt++;
    end
    r.out_red = hit ? 8'd255 : pr[7:0];
    r.out_green = hit ? 8'd255 : pg[7:0];
    r.out_blue = hit ? 8'd255 : pb[7:0];
    r.is_match = hit;
    r.frame_done = px.end_of_frame;
    r.centroid_x = cen_x[15:0];
    r.centroid_y = cen_y[15:0];
    r.centroid_updated = upd;
    return r;
  endfunction

  // Offer one pixel, with an optional random gap first; the caller lowers valid.
  task automatic send_pixel(input pix_in_t px, input bit typed, input pix_out_t typed_val);
    pix_out_t e;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= px;
    do @(posedge clk_i); while (in_stall_o);
    e = track_pixel(px);
    if (typed) begin
      e.out_red = typed_val.out_red;
      e.out_green = typed_val.out_green;
      e.out_blue = typed_val.out_blue;
      e.is_match = typed_val.is_match;
    end
    expected_pixels.push_back(e);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TOLERANCE: reg_val[idx] = v & 32'h3FF;
      CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT: reg_val[idx] = v & 32'h1FFF;
      default: reg_val[idx] = v & 32'hFF;
    endcase
    @(negedge clk_i);
  endtask

  // Wait until the block is idle, then load a full register set.
  task automatic load_settings(input int unsigned tr, tg, tb, tol, stp, w, h);
    in_valid_i <= 1'b0;
    wait (expected_pixels.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    @(negedge clk_i);
    write_reg(CFG_TARGET_RED, tr);
    write_reg(CFG_TARGET_GREEN, tg);
    write_reg(CFG_TARGET_BLUE, tb);
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_LEVEL_STEP, stp);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] near_channel(longint unsigned t, int unsigned spread);
    int v;
    v = int'(t) + int'($urandom_range(0, 2 * spread)) - int'(spread);
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
  endfunction

  // One frame of n pixels, mostly near the target, with an occasional early frame end.
  task automatic send_frame(input int unsigned n, input int unsigned near_pct);
    pix_in_t px;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < near_pct) begin
        px.pixel_red = near_channel(reg_val[CFG_TARGET_RED], 24);
        px.pixel_green = near_channel(reg_val[CFG_TARGET_GREEN], 24);
        px.pixel_blue = near_channel(reg_val[CFG_TARGET_BLUE], 24);
      end else begin
        px.pixel_red = 8'($urandom_range(0, 255));
        px.pixel_green = 8'($urandom_range(0, 255));
        px.pixel_blue = 8'($urandom_range(0, 255));
      end
      px.end_of_frame = (i == n - 1) || ($urandom_range(0, 59) == 0);
      send_pixel(px, 1'b0, '0);
    end
  endtask

  // Cycle limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver stall: short random bursts, or one long hold when asked.
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left--;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare every accepted output item with the oldest expectation.
  always @(posedge clk_i) begin : check_out
    pix_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output item %p", out_data_o);
      end else begin
        e = expected_pixels.pop_front();
        if (out_data_o.out_red !== e.out_red || out_data_o.out_green !== e.out_green
            || out_data_o.out_blue !== e.out_blue || out_data_o.is_match !== e.is_match
            || out_data_o.frame_done !== e.frame_done
            || out_data_o.centroid_x !== e.centroid_x
            || out_data_o.centroid_y !== e.centroid_y
            || out_data_o.centroid_updated !== e.centroid_updated) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected %p", e);
            $display("          actual   %p", out_data_o);
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin : run
    pix_out_t tv;
    pix_in_t px;
    int unsigned tr, tg, tb, tol, stp, w, h;
    reg_val[CFG_TARGET_RED] = 0;
    reg_val[CFG_TARGET_GREEN] = 0;
    reg_val[CFG_TARGET_BLUE] = 0;
    reg_val[CFG_TOLERANCE] = 40;
    reg_val[CFG_LEVEL_STEP] = 55;
    reg_val[CFG_FRAME_WIDTH] = 320;
    reg_val[CFG_FRAME_HEIGHT] = 240;
    col_cnt = 0; row_cnt = 0; x_acc = 0; y_acc = 0; hit_cnt = 0; cen_x = 0; cen_y = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed pixels at the reset settings.
    foreach (dir_rows[i]) begin
      tv = '0;
      tv.out_red = dir_rows[i].r;
      tv.out_green = dir_rows[i].g;
      tv.out_blue = dir_rows[i].b;
      tv.is_match = dir_rows[i].hit;
      send_pixel(dir_rows[i].px, dir_rows[i].typed, tv);
    end

    // Phases of settings, extremes first, then random ones.
    for (int ph = 0; ph < 14; ph++) begin
      tr = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 255 : $urandom_range(0, 255);
      tg = (ph % 4 == 1) ? 0 : (ph % 4 == 2) ? 255 : $urandom_range(0, 255);
      tb = (ph % 5 == 2) ? 255 : (ph % 5 == 3) ? 0 : $urandom_range(0, 255);
      tol = (ph == 1) ? 0 : (ph == 2) ? 766 : (ph == 3) ? 1023 : $urandom_range(60, 400);
      stp = (ph == 4) ? 0 : (ph == 5) ? 1 : (ph == 6) ? 255 : $urandom_range(1, 64);
      w = (ph == 7) ? 0 : (ph == 8) ? 4096 : (ph == 9) ? 8191 : $urandom_range(2, 12);
      h = (ph == 10) ? 0 : (ph == 11) ? 4096 : (ph == 12) ? 8191 : $urandom_range(2, 12);
      load_settings(tr, tg, tb, tol, stp, w, h);
      // Let the receiver hold off while pixels keep coming.
      if (ph == 3) hold_req = 1'b1;
      send_frame($urandom_range(32, 70), 80);
      // Sender waits for every output before the next frame.
      if (ph == 5) begin
        in_valid_i <= 1'b0;
        wait (expected_pixels.size() == 0);
        @(negedge clk_i);
      end
      send_frame($urandom_range(10, 40), 60);
    end

    // One-pixel-wide frame: every pixel moves on to a new row.
    load_settings($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                  766, 1, 1, $urandom_range(1, 64));
    for (int unsigned i = 0; i < 120; i++) begin
      px.pixel_red = 8'($urandom_range(0, 255));
      px.pixel_green = 8'($urandom_range(0, 255));
      px.pixel_blue = 8'($urandom_range(0, 255));
      px.end_of_frame = (i == 119);
      send_pixel(px, 1'b0, '0);
    end

    // Final stretch with no idling on either side.
    load_settings($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(100, 500), $urandom_range(1, 32), $urandom_range(2, 10),
                  $urandom_range(2, 10));
    quiet = 1'b1;
    send_frame(60, 85);
    send_frame(50, 85);
    in_valid_i <= 1'b0;

    wait (expected_pixels.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
